// File: hw/rtl/cpualu_pkg.sv
// Shared types and operation codes for the flag-producing ALU.
// Holds the request and result payload structs; no dependencies.
package cpualu_pkg;

  localparam int unsigned ModeW = 5;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 3;

  // Operation codes; codes above MODE_RES are undefined and pass flags through
  localparam logic [ModeW-1:0] MODE_ADD   = 5'd0;
  localparam logic [ModeW-1:0] MODE_ADC   = 5'd1;
  localparam logic [ModeW-1:0] MODE_SUB   = 5'd2;
  localparam logic [ModeW-1:0] MODE_SBC   = 5'd3;
  localparam logic [ModeW-1:0] MODE_AND   = 5'd4;
  localparam logic [ModeW-1:0] MODE_OR    = 5'd5;
  localparam logic [ModeW-1:0] MODE_XOR   = 5'd6;
  localparam logic [ModeW-1:0] MODE_CP    = 5'd7;
  localparam logic [ModeW-1:0] MODE_INC8  = 5'd8;
  localparam logic [ModeW-1:0] MODE_DEC8  = 5'd9;
  localparam logic [ModeW-1:0] MODE_INC16 = 5'd10;
  localparam logic [ModeW-1:0] MODE_DEC16 = 5'd11;
  localparam logic [ModeW-1:0] MODE_ADDHL = 5'd12;
  localparam logic [ModeW-1:0] MODE_ADDSP = 5'd13;
  localparam logic [ModeW-1:0] MODE_RLC   = 5'd14;
  localparam logic [ModeW-1:0] MODE_RRC   = 5'd15;
  localparam logic [ModeW-1:0] MODE_RL    = 5'd16;
  localparam logic [ModeW-1:0] MODE_RR    = 5'd17;
  localparam logic [ModeW-1:0] MODE_SLA   = 5'd18;
  localparam logic [ModeW-1:0] MODE_SRA   = 5'd19;
  localparam logic [ModeW-1:0] MODE_SWAP  = 5'd20;
  localparam logic [ModeW-1:0] MODE_SRL   = 5'd21;
  localparam logic [ModeW-1:0] MODE_BIT   = 5'd22;
  localparam logic [ModeW-1:0] MODE_SET   = 5'd23;
  localparam logic [ModeW-1:0] MODE_RES   = 5'd24;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic [IdxW-1:0]  bit_index;
    logic             zero_in;
    logic             subtract_in;
    logic             half_in;
    logic             carry_in;
  } alu_req_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic             zero_out;
    logic             subtract_out;
    logic             half_out;
    logic             carry_out;
  } alu_rsp_t;

endpackage

// File: hw/rtl/cpu_alu_with_flags.sv
// Flag-producing 8/16-bit ALU with a registered request and result stage.
// Depends on cpualu_pkg for the payload structs and operation codes.
//
// Usage:
//   Requests arrive on the op channel (op_valid, op_stall, op) and results
//   leave on the res channel (res_valid, res_stall, res). A transfer happens
//   on a rising edge with valid high and stall low. Each request yields
//   exactly one result, in order.
//   The request register loads at the transfer edge, the ALU logic then loads
//   the result register from it once the result register may advance, and
//   res_valid is high from then on.
//   Throughput is one item per cycle while res_stall is low; the ALU logic
//   between the two registers finishes any operation in a single pass.
//   When the receiver stalls, the result register holds and the request
//   register keeps filling; op_stall rises only when both are occupied and
//   res_stall is high, so no transfer is lost.
//   Synchronous reset empties both stages; payloads are not cleared.
module cpu_alu_with_flags (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_stall,
  input  cpualu_pkg::alu_req_t op,
  output logic                 res_valid,
  input  logic                 res_stall,
  output cpualu_pkg::alu_rsp_t res
);
  import cpualu_pkg::*;

  alu_req_t   held;
  logic       held_valid;
  alu_rsp_t   calc;
  logic       res_adv;
  logic       held_adv;

  logic [ByteW-1:0]   a;
  logic [ByteW-1:0]   b;
  logic               cin;
  logic [ByteW:0]     sum9;
  logic [4:0]         nib5;
  logic [ByteW:0]     dif9;
  logic [4:0]         nibd5;
  logic [ByteW-1:0]   v8;
  logic [WordW:0]     sum17;
  logic [12:0]        sum13;
  logic [ByteW:0]     sp9;
  logic [ByteW-1:0]   bit_mask;

  assign res_adv  = !res_valid || !res_stall;
  assign held_adv = !held_valid || res_adv;
  assign op_stall = !held_adv;

  always_comb begin
    a        = held.operand_a[ByteW-1:0];
    b        = held.operand_b[ByteW-1:0];
    cin      = ((held.mode == MODE_ADC) || (held.mode == MODE_SBC)) && held.carry_in;
    sum9     = {1'b0, a} + {1'b0, b} + {{ByteW{1'b0}}, cin};
    nib5     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    dif9     = {1'b0, a} - {1'b0, b} - {{ByteW{1'b0}}, cin};
    nibd5    = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
    sum17    = {1'b0, held.operand_a} + {1'b0, held.operand_b};
    sum13    = {1'b0, held.operand_a[11:0]} + {1'b0, held.operand_b[11:0]};
    sp9      = {1'b0, held.operand_a[ByteW-1:0]} + {1'b0, b};
    bit_mask = {{(ByteW-1){1'b0}}, 1'b1} << held.bit_index;
    v8       = '0;

    // default: pass flags through, zero value (undefined codes land here)
    calc.result       = '0;
    calc.zero_out     = held.zero_in;
    calc.subtract_out = held.subtract_in;
    calc.half_out     = held.half_in;
    calc.carry_out    = held.carry_in;

    unique case (held.mode)
      MODE_ADD, MODE_ADC: begin
        v8 = sum9[ByteW-1:0];
        calc.result       = {8'h00, v8};
        calc.zero_out     = (v8 == '0);
        calc.subtract_out = 1'b0;
        calc.half_out     = nib5[4];
        calc.carry_out    = sum9[ByteW];
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        v8 = dif9[ByteW-1:0];
        // compare keeps operand a but flags follow the difference
        calc.result       = {8'h00, (held.mode == MODE_CP) ? a : v8};
        calc.zero_out     = (v8 == '0);
        calc.subtract_out = 1'b1;
        calc.half_out     = nibd5[4];
        calc.carry_out    = dif9[ByteW];
      end
      MODE_AND: begin
        v8 = a & b;
        calc.result       = {8'h00, v8};
        calc.zero_out     = (v8 == '0);
        calc.subtract_out = 1'b0;
        calc.half_out     = 1'b1;
        calc.carry_out    = 1'b0;
      end
      MODE_OR, MODE_XOR: begin
        v8 = (held.mode == MODE_OR) ? (a | b) : (a ^ b);
        calc.result       = {8'h00, v8};
        calc.zero_out     = (v8 == '0);
        calc.subtract_out = 1'b0;
        calc.half_out     = 1'b0;
        calc.carry_out    = 1'b0;
      end
      MODE_INC8: begin
        v8 = a + 8'd1;
        calc.result       = {8'h00, v8};
        calc.zero_out     = (v8 == '0);
        calc.subtract_out = 1'b0;
        calc.half_out     = (v8[3:0] == 4'h0);
      end
      MODE_DEC8: begin
        v8 = a - 8'd1;
        calc.result       = {8'h00, v8};
        calc.zero_out     = (v8 == '0);
        calc.subtract_out = 1'b1;
        calc.half_out     = (v8[3:0] == 4'hF);
      end
      MODE_INC16: calc.result = held.operand_a + 16'd1;
      MODE_DEC16: calc.result = held.operand_a - 16'd1;
      MODE_ADDHL: begin
        calc.result       = sum17[WordW-1:0];
        calc.subtract_out = 1'b0;
        calc.half_out     = sum13[12];
        calc.carry_out    = sum17[WordW];
      end
      MODE_ADDSP: begin
        // offset is a signed byte; carries come from the unsigned low byte add
        calc.result       = held.operand_a + {{ByteW{b[ByteW-1]}}, b};
        calc.zero_out     = 1'b0;
        calc.subtract_out = 1'b0;
        calc.half_out     = nib5[4];
        calc.carry_out    = sp9[ByteW];
      end
      MODE_RLC, MODE_RRC, MODE_RL, MODE_RR,
      MODE_SLA, MODE_SRA, MODE_SWAP, MODE_SRL: begin
        case (held.mode)
          MODE_RLC: begin
            v8 = {a[6:0], a[7]};
            calc.carry_out = a[7];
          end
          MODE_RRC: begin
            v8 = {a[0], a[7:1]};
            calc.carry_out = a[0];
          end
          MODE_RL: begin
            v8 = {a[6:0], held.carry_in};
            calc.carry_out = a[7];
          end
          MODE_RR: begin
            v8 = {held.carry_in, a[7:1]};
            calc.carry_out = a[0];
          end
          MODE_SLA: begin
            v8 = {a[6:0], 1'b0};
            calc.carry_out = a[7];
          end
          MODE_SRA: begin
            v8 = {a[7], a[7:1]};
            calc.carry_out = a[0];
          end
          MODE_SWAP: begin
            v8 = {a[3:0], a[7:4]};
            calc.carry_out = 1'b0;
          end
          default: begin
            v8 = {1'b0, a[7:1]};
            calc.carry_out = a[0];
          end
        endcase
        calc.result       = {8'h00, v8};
        calc.zero_out     = (v8 == '0);
        calc.subtract_out = 1'b0;
        calc.half_out     = 1'b0;
      end
      MODE_BIT: begin
        calc.result       = {8'h00, a};
        calc.zero_out     = !a[held.bit_index];
        calc.subtract_out = 1'b0;
        calc.half_out     = 1'b1;
      end
      MODE_SET: calc.result = {8'h00, a | bit_mask};
      MODE_RES: calc.result = {8'h00, a & ~bit_mask};
      default: ;
    endcase
  end

  // request stage: load on transfer, drop when passed on
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (held_adv) begin
      held_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (held_adv && op_valid) begin
      held <= op;
    end
  end

  // result stage: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_adv) begin
      res_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_adv && held_valid) begin
      res <= calc;
    end
  end

endmodule
